// ===== rtl/core/skf_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the scalar kalman filter core
// no dependencies; used by skf_div, skf_mul and scalar_kalman_filter_core

package skf_pkg;

   localparam int DATA_W            = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int CSR_ADDR_W        = 2;

   // multiplier operand width: 32-bit values plus a sign bit
   localparam int MUL_W  = DATA_W + 1;
   localparam int PROD_W = 2 * MUL_W;

   // register indexes on the csr port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PROCESS_NOISE  = 2'd0,
      CSR_MEASURE_NOISE  = 2'd1,
      CSR_START_ESTIMATE = 2'd2,
      CSR_START_ERROR    = 2'd3
   } csr_index_type;

   // register reset values
   localparam logic [DATA_W-1:0] RST_PROCESS_NOISE  = 32'd655;
   localparam logic [DATA_W-1:0] RST_MEASURE_NOISE  = 32'd78643;
   localparam logic [DATA_W-1:0] RST_START_ESTIMATE = 32'd0;
   localparam logic [DATA_W-1:0] RST_START_ERROR    = 32'd65536;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL_GAIN,
      ST_MUL_ERR,
      ST_MUL_NOISE,
      ST_SUM,
      ST_DONE
   } skf_state_type;

   // what the shared multiplier is fed with
   typedef enum logic [1:0] {
      MSEL_GAIN_INNOV,
      MSEL_COMP_ERR,
      MSEL_MAG_NOISE
   } skf_mul_sel_type;

endpackage

// ===== rtl/core/skf_div.sv =====
`timescale 1ns / 1ps
// iterative restoring divider for the filter gain, one quotient bit per cycle
// depends on skf_pkg

module skf_div #(
   parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [skf_pkg::DATA_W-1:0]   num,   // must be below den
   input  logic [skf_pkg::DATA_W:0]     den,
   output logic                         done,
   output logic [FRAC_BITS-1:0]         quo
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam int REM_W = skf_pkg::DATA_W + 2;

   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [skf_pkg::DATA_W:0]    den_ff, den_in;
   logic [FRAC_BITS-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] rem_diff;
   logic             fits;

   always_comb begin
      rem_sh   = {rem_ff[REM_W-2:0], 1'b0};
      rem_diff = rem_sh - {1'b0, den_ff};
      fits     = rem_sh >= {1'b0, den_ff};
   end

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {2'b00, num};
         den_in  = den;
         quo_in  = '0;
         cnt_in  = CNT_W'(FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff : rem_sh;
         quo_in = {quo_ff[FRAC_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/core/skf_mul.sv =====
`timescale 1ns / 1ps
// shared signed multiplier with a registered product
// depends on skf_pkg

module skf_mul (
   input  logic                                clock,
   input  logic signed [skf_pkg::MUL_W-1:0]    mul_a,
   input  logic signed [skf_pkg::MUL_W-1:0]    mul_b,
   output logic signed [skf_pkg::PROD_W-1:0]   prod
);

   logic signed [skf_pkg::PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      prod_in = skf_pkg::PROD_W'(mul_a) * skf_pkg::PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/scalar_kalman_filter_core.sv =====
`timescale 1ns / 1ps
// one-dimensional fixed-point kalman filter, top level with the sequencer
// depends on skf_pkg, skf_div and skf_mul

// Each req beat carries one signed Q15.16 measurement (FRAC_BITS fraction bits) and
// produces exactly one rsp beat with the updated estimate and the updated error.
// The gain error/(error+measure_noise) comes from a restoring divider that makes one
// quotient bit per cycle; the three products (gain times innovation, one minus gain
// times error, residual times process noise) then go one after another through a
// single registered 33x33 multiplier. An item passes through the divider's bit loop
// and then four multiplier/adder steps before rsp_tvalid rises; req_tready is high
// only while the core is idle. The finished beat sits in an output register, so the
// next sample can be taken while it waits. Writing start_estimate or start_error
// through the csr port also loads the running estimate or error; csr writes belong
// in idle periods only.

module scalar_kalman_filter_core #(
   parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // measurement beats
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [skf_pkg::DATA_W-1:0]             req_tdata,   // [31:0] sample
   // result beats
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [2*skf_pkg::DATA_W-1:0]           rsp_tdata,   // [31:0] filtered,
                                                              // [63:32] uncertainty
   // register writes
   input  logic                                   csr_we,
   input  logic [skf_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  logic [skf_pkg::DATA_W-1:0]             csr_wdata
);

   localparam int DW    = skf_pkg::DATA_W;
   localparam int MW    = skf_pkg::MUL_W;
   localparam int GW    = FRAC_BITS + 1;
   localparam int T2W   = 2 * DW - FRAC_BITS;
   localparam logic [GW-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // registers
   logic [DW-1:0] process_noise_ff, measure_noise_ff;
   logic [DW-1:0] est_ff, est_in;
   logic [DW-1:0] err_ff, err_in;
   logic [DW-1:0] meas_ff;
   logic [GW-1:0] gain_ff;
   logic [DW-1:0] newest_ff;
   logic [DW-1:0] t1_ff;
   logic [DW-1:0] sum_ff;
   logic [DW-1:0] out_filtered_ff, out_uncert_ff;
   logic          rsp_tvalid_ff, rsp_tvalid_in;

   skf_pkg::skf_state_type state_ff, state_in;

   // sequencer outputs
   logic                     div_start;
   logic                     load_meas;
   logic                     load_gain;
   logic                     load_newest;
   logic                     load_t1;
   logic                     load_sum;
   logic                     commit;
   skf_pkg::skf_mul_sel_type mul_sel;

   // datapath
   logic                         req_beat;
   logic                         out_free;
   logic                         div_done;
   logic [FRAC_BITS-1:0]         div_quo;
   logic [DW:0]                  den;
   logic [GW-1:0]                gain_sel;
   logic signed [MW-1:0]         innov;
   logic [GW-1:0]                gain_comp;
   logic signed [MW-1:0]         diff;
   logic [MW-1:0]                mag_full;
   logic [DW-1:0]                mag;
   logic signed [MW-1:0]         mul_a, mul_b;
   logic signed [skf_pkg::PROD_W-1:0] prod;
   logic [DW+1:0]                newest_sum;
   logic [T2W:0]                 err_sum;
   logic [DW-1:0]                err_sat;

   assign req_beat = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // gain denominator kept one bit wider so it never wraps
   assign den = {1'b0, err_ff} + {1'b0, measure_noise_ff};

   skf_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (err_ff),
      .den   (den),
      .done  (div_done),
      .quo   (div_quo)
   );

   skf_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   always_comb begin
      // zero measure noise: error/error is exactly one, or zero when both are zero
      if (measure_noise_ff == '0) begin
         gain_sel = (err_ff != '0) ? GAIN_ONE : '0;
      end else begin
         gain_sel = {1'b0, div_quo};
      end

      innov     = $signed({meas_ff[DW-1], meas_ff}) - $signed({est_ff[DW-1], est_ff});
      gain_comp = GAIN_ONE - gain_ff;

      // residual between the new estimate and the measurement
      diff     = $signed({newest_ff[DW-1], newest_ff}) - $signed({meas_ff[DW-1], meas_ff});
      mag_full = diff[MW-1] ? MW'(-diff) : MW'(diff);
      mag      = mag_full[MW-1] ? '1 : mag_full[DW-1:0];

      case (mul_sel)
         skf_pkg::MSEL_GAIN_INNOV: begin
            mul_a = $signed(MW'(gain_ff));
            mul_b = innov;
         end
         skf_pkg::MSEL_COMP_ERR: begin
            mul_a = $signed(MW'(gain_comp));
            mul_b = $signed({1'b0, err_ff});
         end
         skf_pkg::MSEL_MAG_NOISE: begin
            mul_a = $signed({1'b0, mag});
            mul_b = $signed({1'b0, process_noise_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      // floor shift of the gain product, added to the old estimate
      newest_sum = prod[FRAC_BITS+DW+1:FRAC_BITS] + {{2{est_ff[DW-1]}}, est_ff};

      // truncated error terms, sum saturated at all ones
      err_sum = (T2W + 1)'(t1_ff) + {1'b0, prod[2*DW-1:FRAC_BITS]};
      err_sat = (|err_sum[T2W:DW]) ? '1 : err_sum[DW-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skf_pkg::ST_IDLE:      if (req_beat) state_in = skf_pkg::ST_DIV;
         skf_pkg::ST_DIV:       if (div_done) state_in = skf_pkg::ST_MUL_GAIN;
         skf_pkg::ST_MUL_GAIN:  state_in = skf_pkg::ST_MUL_ERR;
         skf_pkg::ST_MUL_ERR:   state_in = skf_pkg::ST_MUL_NOISE;
         skf_pkg::ST_MUL_NOISE: state_in = skf_pkg::ST_SUM;
         skf_pkg::ST_SUM:       state_in = skf_pkg::ST_DONE;
         skf_pkg::ST_DONE:      if (out_free) state_in = skf_pkg::ST_IDLE;
         default:               state_in = skf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      div_start   = 1'b0;
      load_meas   = 1'b0;
      load_gain   = 1'b0;
      load_newest = 1'b0;
      load_t1     = 1'b0;
      load_sum    = 1'b0;
      commit      = 1'b0;
      mul_sel     = skf_pkg::MSEL_GAIN_INNOV;
      case (state_ff)
         skf_pkg::ST_IDLE: begin
            // no beat is taken while reset is held
            req_tready = !reset;
            div_start  = req_tvalid;
            load_meas  = req_tvalid;
         end
         skf_pkg::ST_DIV: begin
            load_gain = div_done;
         end
         skf_pkg::ST_MUL_GAIN: begin
            mul_sel = skf_pkg::MSEL_GAIN_INNOV;
         end
         skf_pkg::ST_MUL_ERR: begin
            load_newest = 1'b1;
            mul_sel     = skf_pkg::MSEL_COMP_ERR;
         end
         skf_pkg::ST_MUL_NOISE: begin
            load_t1 = 1'b1;
            mul_sel = skf_pkg::MSEL_MAG_NOISE;
         end
         skf_pkg::ST_SUM: begin
            load_sum = 1'b1;
         end
         skf_pkg::ST_DONE: begin
            commit = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // running state: csr loads, then the committed update
   always_comb begin
      est_in = est_ff;
      err_in = err_ff;
      if (csr_we && csr_addr == skf_pkg::CSR_START_ESTIMATE) est_in = csr_wdata;
      if (csr_we && csr_addr == skf_pkg::CSR_START_ERROR)    err_in = csr_wdata;
      if (commit) begin
         est_in = newest_ff;
         err_in = sum_ff;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (commit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= skf_pkg::ST_IDLE;
         rsp_tvalid_ff     <= 1'b0;
         process_noise_ff  <= skf_pkg::RST_PROCESS_NOISE;
         measure_noise_ff  <= skf_pkg::RST_MEASURE_NOISE;
         est_ff            <= skf_pkg::RST_START_ESTIMATE;
         err_ff            <= skf_pkg::RST_START_ERROR;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         est_ff        <= est_in;
         err_ff        <= err_in;
         // start values only load the running state, handled above
         if (csr_we) begin
            case (csr_addr)
               skf_pkg::CSR_PROCESS_NOISE:  process_noise_ff  <= csr_wdata;
               skf_pkg::CSR_MEASURE_NOISE:  measure_noise_ff  <= csr_wdata;
               default:                     process_noise_ff  <= process_noise_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load_meas)   meas_ff   <= req_tdata;
      if (load_gain)   gain_ff   <= gain_sel;
      if (load_newest) newest_ff <= newest_sum[DW-1:0];
      if (load_t1)     t1_ff     <= prod[FRAC_BITS+DW-1:FRAC_BITS];
      if (load_sum)    sum_ff    <= err_sat;
      if (commit) begin
         out_filtered_ff <= newest_ff;
         out_uncert_ff   <= sum_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {out_uncert_ff, out_filtered_ff};

`ifndef ASSERT_OFF
   // the divider only finishes while the sequencer waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == skf_pkg::ST_DIV)
      else $error("divider finished outside the divide state");

   // an accepted sample always starts a division
   a_beat_starts_div: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> state_ff == skf_pkg::ST_DIV)
      else $error("accepted sample did not enter the divide state");

   // the gain never exceeds one
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      load_gain |-> gain_sel <= GAIN_ONE)
      else $error("gain above one");

   // a finished item waits while the previous result is still held
   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skf_pkg::ST_DONE && rsp_tvalid_ff && !rsp_tready)
      |=> state_ff == skf_pkg::ST_DONE && rsp_tvalid_ff)
      else $error("result overwritten before it was taken");

   // the running state only moves on a commit or a csr load
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (!commit && !csr_we) |=> $stable(est_ff) && $stable(err_ff))
      else $error("running estimate changed without a commit");
`endif

endmodule
